>>> hdl/bounding_sphere_grow_macros.svh
// Assertion macros of the bounding sphere top level.
`ifndef BOUNDING_SPHERE_GROW_MACROS_SVH
`define BOUNDING_SPHERE_GROW_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define BSG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define BSG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> hdl/bsg_pkg.sv
// Package with widths and state codes of the bounding sphere block.
package bsg_pkg;
  localparam int CoordW = 32;
  localparam int RadW   = 33;
  localparam int OffW   = 33;
  localparam int SqW    = 66;
  localparam int DividW = 66;
  localparam int CntW   = 7;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SQ   = 4'd1;
  localparam logic [3:0] ST_SQRT = 4'd2;
  localparam logic [3:0] ST_CMP  = 4'd3;
  localparam logic [3:0] ST_MUL  = 4'd4;
  localparam logic [3:0] ST_DIV  = 4'd5;
  localparam logic [3:0] ST_UPD  = 4'd6;
  localparam logic [3:0] ST_OUT  = 4'd7;
endpackage

>>> hdl/bsg_serial_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle, 33 by 33 bits unsigned.
module bsg_serial_mul (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [bsg_pkg::OffW-1:0]  op_a,
  input  logic [bsg_pkg::OffW-1:0]  op_b,
  output logic                      done,
  output logic [bsg_pkg::SqW-1:0]   prod
);
  import bsg_pkg::*;

  logic [SqW-1:0]  acc_r, acc_nxt;
  logic [OffW-1:0] mcand_r, mcand_nxt;
  logic [OffW-1:0] mplier_r, mplier_nxt;
  logic [5:0]      cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic [OffW:0]   upper;

  // Product shifts right each cycle; the upper half takes the partial add.
  assign upper = {1'b0, acc_r[SqW-1:OffW]} + (mplier_r[0] ? {1'b0, mcand_r} : '0);

  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    if (start) begin
      acc_nxt    = '0;
      mcand_nxt  = op_a;
      mplier_nxt = op_b;
      cnt_nxt    = 6'(OffW);
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      acc_nxt    = {upper, acc_r[OffW-1:1]};
      mplier_nxt = mplier_r >> 1;
      cnt_nxt    = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign done = busy_r && (cnt_r == 6'd1);
  assign prod = {upper, acc_r[OffW-1:1]};
endmodule

>>> hdl/bounding_sphere_grow.sv
// Top level of the streaming bounding sphere growth block.
//
//  channel | direction | word contents
//  in_     | slave     | tuser: restart; tdata: point_x, point_y, point_z
//  out_    | master    | tuser: grown; tdata: center_x, center_y, center_z, sphere_radius
//  cfg_    | write     | index 0..3: init_center_x/y/z, init_radius
//
// One word is worked on at a time. A word passes an accept step, three serial squarings,
// a 33-step square root and a compare; a growing point then takes three rounds of
// serial multiply, 66-step restoring division and update.
// Reset is synchronous and active low; it clears the sphere and the control.
// The result sits in an output register; a stalled output only holds the block.
module bounding_sphere_grow (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // point_x [31:0], point_y [63:32], point_z [95:64]
  input  logic         in_tuser,   // restart
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // center_x, center_y, center_z, sphere_radius, zero fill
  output logic         out_tuser,  // grown
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [32:0]  cfg_wdata
);
  import bsg_pkg::*;

  localparam logic [1:0] REG_CX  = 2'd0;
  localparam logic [1:0] REG_CY  = 2'd1;
  localparam logic [1:0] REG_CZ  = 2'd2;
  localparam logic [1:0] REG_RAD = 2'd3;

  logic [CoordW-1:0] init_x_r, init_y_r, init_z_r;
  logic [RadW-1:0]   init_r_r;
  logic [CoordW-1:0] cx_r, cy_r, cz_r, cx_nxt, cy_nxt, cz_nxt;
  logic [RadW-1:0]   rad_r, rad_nxt;
  logic [3:0]        st_r, st_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic [1:0]        ax_r, ax_nxt;       // axis being processed
  logic [OffW-1:0]   off_r [3];
  logic [OffW-1:0]   off_nxt [3];
  logic [SqW:0]      sq_r, sq_nxt;       // sum of squares
  logic [34:0]       rem_r, rem_nxt;     // root remainder
  logic [RadW-1:0]   root_r, root_nxt;
  logic [RadW-1:0]   mv_r, mv_nxt;
  logic [DividW-1:0] dvd_r, dvd_nxt;     // dividend shifting out, quotient in
  logic [RadW:0]     drem_r, drem_nxt;
  logic              grown_r, grown_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic              mul_start;
  logic              mul_done;
  logic [SqW-1:0]    mul_prod;
  logic [OffW-1:0]   mul_a, mul_b, mag_cur;
  logic [34:0]       rtrial, rshift;
  logic [RadW+1:0]   dshift;
  logic [RadW-1:0]   rsum_half;
  logic [OffW:0]     qext;

  assign mag_cur = off_r[ax_r][OffW-1] ? (~off_r[ax_r] + 1'b1) : off_r[ax_r];
  assign mul_a   = mag_cur;
  assign mul_b   = (st_r == ST_SQ) ? mag_cur : mv_r;

  bsg_serial_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // Root step: two bits of the radicand enter per cycle.
  assign rshift = {rem_r[32:0], sq_r[65:64]};
  assign rtrial = {root_r[32:0], 2'b01};
  // Divider step: one dividend bit per cycle against the distance.
  assign dshift = {drem_r, dvd_r[DividW-1]};
  assign rsum_half = RadW'(({1'b0, rad_r} + {1'b0, root_r}) >> 1);
  assign qext = {1'b0, dvd_r[OffW-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_x_r <= '0;
      init_y_r <= '0;
      init_z_r <= '0;
      init_r_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CX:  init_x_r <= cfg_wdata[CoordW-1:0];
        REG_CY:  init_y_r <= cfg_wdata[CoordW-1:0];
        REG_CZ:  init_z_r <= cfg_wdata[CoordW-1:0];
        REG_RAD: init_r_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    st_nxt     = st_r;
    cnt_nxt    = cnt_r;
    ax_nxt     = ax_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    cz_nxt     = cz_r;
    rad_nxt    = rad_r;
    off_nxt    = off_r;
    sq_nxt     = sq_r;
    rem_nxt    = rem_r;
    root_nxt   = root_r;
    mv_nxt     = mv_r;
    dvd_nxt    = dvd_r;
    drem_nxt   = drem_r;
    grown_nxt  = grown_r;
    ovalid_nxt = ovalid_r;
    mul_start  = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          // Restart reloads the sphere before the offsets are formed.
          if (in_tuser) begin
            cx_nxt  = init_x_r;
            cy_nxt  = init_y_r;
            cz_nxt  = init_z_r;
            rad_nxt = init_r_r;
          end
          off_nxt[0] = {in_tdata[31], in_tdata[31:0]}
                     - {cx_nxt[CoordW-1], cx_nxt};
          off_nxt[1] = {in_tdata[63], in_tdata[63:32]}
                     - {cy_nxt[CoordW-1], cy_nxt};
          off_nxt[2] = {in_tdata[95], in_tdata[95:64]}
                     - {cz_nxt[CoordW-1], cz_nxt};
          sq_nxt = '0;
          ax_nxt = 2'd0;
          st_nxt = ST_SQ;
          cnt_nxt = '0;
        end
      end
      ST_SQ: begin
        if (cnt_r == '0) begin
          mul_start = 1'b1;
          cnt_nxt = 7'd1;
        end else if (mul_done) begin
          sq_nxt = sq_r + {1'b0, mul_prod};
          cnt_nxt = '0;
          if (ax_r == 2'd2) begin
            // The sum stays below 2^66, so 33 bit pairs cover it.
            st_nxt   = ST_SQRT;
            cnt_nxt  = 7'd32;
            rem_nxt  = '0;
            root_nxt = '0;
          end else begin
            ax_nxt = ax_r + 2'd1;
          end
        end
      end
      ST_SQRT: begin
        sq_nxt = {sq_r[SqW-2:0], 2'b00};
        if (rshift >= rtrial) begin
          rem_nxt  = rshift - rtrial;
          root_nxt = {root_r[RadW-2:0], 1'b1};
        end else begin
          rem_nxt  = rshift;
          root_nxt = {root_r[RadW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == '0) st_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (root_r > rad_r) begin
          grown_nxt = 1'b1;
          rad_nxt   = rsum_half;
          mv_nxt    = root_r - rsum_half;
          ax_nxt    = 2'd0;
          cnt_nxt   = '0;
          st_nxt    = ST_MUL;
        end else begin
          grown_nxt = 1'b0;
          st_nxt    = ST_OUT;
        end
      end
      ST_MUL: begin
        if (cnt_r == '0) begin
          mul_start = 1'b1;
          cnt_nxt = 7'd1;
        end else if (mul_done) begin
          dvd_nxt  = mul_prod;
          drem_nxt = '0;
          cnt_nxt  = 7'(DividW - 1);
          st_nxt   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (dshift >= {1'b0, root_r}) begin
          drem_nxt = (RadW+1)'(dshift - {1'b0, root_r});
          dvd_nxt  = {dvd_r[DividW-2:0], 1'b1};
        end else begin
          drem_nxt = dshift[RadW:0];
          dvd_nxt  = {dvd_r[DividW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == '0) st_nxt = ST_UPD;
      end
      ST_UPD: begin
        // Quotient stays below the offset, so 33 bits carry it.
        unique case (ax_r)
          2'd0: cx_nxt = off_r[0][OffW-1] ? CoordW'({1'b0, cx_r} - qext)
                                          : CoordW'({1'b0, cx_r} + qext);
          2'd1: cy_nxt = off_r[1][OffW-1] ? CoordW'({1'b0, cy_r} - qext)
                                          : CoordW'({1'b0, cy_r} + qext);
          default: cz_nxt = off_r[2][OffW-1] ? CoordW'({1'b0, cz_r} - qext)
                                             : CoordW'({1'b0, cz_r} + qext);
        endcase
        cnt_nxt = '0;
        if (ax_r == 2'd2) begin
          st_nxt = ST_OUT;
        end else begin
          ax_nxt = ax_r + 2'd1;
          st_nxt = ST_MUL;
        end
      end
      ST_OUT: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          st_nxt     = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
    if (out_tvalid && out_tready && st_r != ST_OUT) ovalid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      cnt_r    <= '0;
      ax_r     <= '0;
      cx_r     <= '0;
      cy_r     <= '0;
      cz_r     <= '0;
      rad_r    <= '0;
      ovalid_r <= 1'b0;
      grown_r  <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      cnt_r    <= cnt_nxt;
      ax_r     <= ax_nxt;
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      cz_r     <= cz_nxt;
      rad_r    <= rad_nxt;
      ovalid_r <= ovalid_nxt;
      grown_r  <= grown_nxt;
    end
    off_r  <= off_nxt;
    sq_r   <= sq_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    mv_r   <= mv_nxt;
    dvd_r  <= dvd_nxt;
    drem_r <= drem_nxt;
  end

  // The output register holds the sphere captured when the word finished.
  logic [135:0] odata_r;
  logic         ogrown_r;
  always_ff @(posedge clk) begin
    if (st_r == ST_OUT && (!ovalid_r || out_tready)) begin
      odata_r  <= {7'd0, rad_r, cz_r, cy_r, cx_r};
      ogrown_r <= grown_r;
    end
  end

  assign in_tready  = (st_r == ST_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ogrown_r;

  `include "bounding_sphere_grow_macros.svh"

  `BSG_ASSERT_IMP(a_busy_no_ready, st_r != ST_IDLE, !in_tready)
  `BSG_ASSERT_NXT(a_accept_starts, in_tvalid && in_tready, st_r == ST_SQ)
  `BSG_ASSERT_IMP(a_div_nonzero, st_r == ST_DIV, root_r != '0)
endmodule

>>> bench/testbench.sv
// Self-checking testbench for the streaming bounding sphere growth block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bsg_pkg::*;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_CX = 2'd0;
  localparam logic [1:0] REG_CY = 2'd1;
  localparam logic [1:0] REG_CZ = 2'd2;
  localparam logic [1:0] REG_RAD = 2'd3;

  localparam int SETTLE_CYCLES = 600;

  typedef struct packed {
    logic                     grown;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] cz;
    logic [RadW-1:0]          rad;
  } sphere_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [95:0] in_tdata;
  logic in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [135:0] out_tdata;
  logic out_tuser;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [32:0] cfg_wdata;

  bounding_sphere_grow i_dut (.*);

  // Registers as the bench believes them, and the running sphere.
  logic signed [CoordW-1:0] init_c [3];
  logic [RadW-1:0] init_rad;
  logic signed [CoordW-1:0] sph_c [3];
  logic [RadW-1:0] sph_rad;

  sphere_t sphere_queue[$];
  int error_count;
  bit rx_hold;  // forces the receiver to stall for a long stretch

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Pick a gap length: mostly zero or short, sometimes long.
  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      return 0;
    end else if (sel < 92) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(10, 80);
  endfunction

  // Floor square root of a 66-bit value, one result bit at a time.
  function automatic logic [33:0] isqrt66(logic [65:0] v);
    logic [33:0] root;
    logic [33:0] cand;
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      cand = root | (34'd1 << b);
      if ({34'd0, cand} * {34'd0, cand} <= {2'd0, v}) begin
        root = cand;
      end
    end
    return root;
  endfunction

  // Apply one point to the running sphere and return the resulting word.
  function automatic sphere_t grow_sphere(logic restart, logic signed [CoordW-1:0] p [3]);
    logic signed [OffW-1:0] off [3];
    logic [32:0] mag [3];
    logic [SqW-1:0] dist_sq;
    logic [33:0] dist_v;
    logic [33:0] new_rad;
    logic [33:0] shift;
    logic [66:0] quot;
    sphere_t res;
    if (restart) begin
      sph_c = init_c;
      sph_rad = init_rad;
    end
    dist_sq = '0;
    for (int k = 0; k < 3; k++) begin
      off[k] = OffW'(p[k]) - OffW'(sph_c[k]);
      mag[k] = off[k] < 0 ? 33'(-off[k]) : 33'(off[k]);
      dist_sq += {33'd0, mag[k]} * {33'd0, mag[k]};
    end
    dist_v = isqrt66(dist_sq);
    res.grown = 1'b0;
    if (dist_v > {1'b0, sph_rad}) begin
      new_rad = ({1'b0, sph_rad} + dist_v) >> 1;
      shift = dist_v - new_rad;
      for (int k = 0; k < 3; k++) begin
        quot = ({34'd0, mag[k]} * {33'd0, shift}) / {33'd0, dist_v};
        if (off[k] < 0) begin
          sph_c[k] = sph_c[k] - CoordW'(quot);
        end else begin
          sph_c[k] = sph_c[k] + CoordW'(quot);
        end
      end
      sph_rad = new_rad[RadW-1:0];
      res.grown = 1'b1;
    end
    res.cx = sph_c[0];
    res.cy = sph_c[1];
    res.cz = sph_c[2];
    res.rad = sph_rad;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Send one point; the expectation is queued when the block accepts it.
  // Valid stays high between back-to-back points and drops only for a gap.
  task automatic send_point(logic restart, logic signed [CoordW-1:0] px,
                            logic signed [CoordW-1:0] py, logic signed [CoordW-1:0] pz);
    logic signed [CoordW-1:0] p [3];
    int gap;
    gap = gap_len();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    in_tvalid <= 1'b1;
    in_tuser <= restart;
    in_tdata <= {pz, py, px};
    do @(posedge clk); while (!in_tready);
    sphere_queue.push_back(grow_sphere(restart, p));
  endtask

  // Write one register; only called while the block is idle.
  task automatic write_reg(logic [1:0] idx, logic [32:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CX: init_c[0] = val[31:0];
      REG_CY: init_c[1] = val[31:0];
      REG_CZ: init_c[2] = val[31:0];
      REG_RAD: init_rad = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_sphere(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [32:0] r);
    write_reg(REG_CX, {1'b0, x});
    write_reg(REG_CY, {1'b0, y});
    write_reg(REG_CZ, {1'b0, z});
    write_reg(REG_RAD, r);
  endtask

  // Wait until every expected word has arrived, then let the block settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sphere_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: random stalls plus a forced hold-off when requested.
  always @(posedge clk) begin
    if (!rst_n || rx_hold) begin
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < 70) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= $urandom_range(0, 99) < 5 ? 1'b0 : 1'b0;
    end
  end

  // Checker: each accepted word is compared against the oldest expectation.
  always @(posedge clk) begin
    sphere_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (sphere_queue.size() == 0) begin
        report_mismatch("unexpected word", out_tdata[63:0], 64'd0);
      end else begin
        want = sphere_queue.pop_front();
        if (out_tuser !== want.grown) begin
          report_mismatch("grown", 64'(out_tuser), 64'(want.grown));
        end
        if (out_tdata[31:0] !== want.cx) begin
          report_mismatch("center_x", 64'(out_tdata[31:0]), 64'(want.cx));
        end
        if (out_tdata[63:32] !== want.cy) begin
          report_mismatch("center_y", 64'(out_tdata[63:32]), 64'(want.cy));
        end
        if (out_tdata[95:64] !== want.cz) begin
          report_mismatch("center_z", 64'(out_tdata[95:64]), 64'(want.cz));
        end
        if (out_tdata[128:96] !== want.rad) begin
          report_mismatch("radius", 64'(out_tdata[128:96]), 64'(want.rad));
        end
      end
    end
  end

  // Extremes of the coordinates, points at the center, on the surface and
  // inside, the largest radius, and a zero-radius sphere that sees its own center.
  task automatic test_directed();
    send_point(1'b1, 32'sd0, 32'sd0, 32'sd0);
    send_point(1'b0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_point(1'b0, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_point(1'b0, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
    send_point(1'b1, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_point(1'b0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_point(1'b0, 32'sd0, 32'sd0, 32'sd0);
    drain();
    // Sphere of radius 1.0 at the origin: surface point leaves it unchanged.
    load_sphere(32'd0, 32'd0, 32'd0, 33'h10000);
    send_point(1'b1, 32'sh10000, 32'sd0, 32'sd0);
    send_point(1'b0, 32'sd0, 32'sd0, -32'sh10000);
    send_point(1'b0, 32'sd0, 32'sh10001, 32'sd0);
    send_point(1'b0, 32'sd5, -32'sd7, 32'sd3);
    drain();
    // Largest radius and extreme centers; writes take effect at the restart.
    load_sphere(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 33'h1FFFFFFFF);
    send_point(1'b0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
    send_point(1'b1, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
    send_point(1'b0, 32'sd0, 32'sd0, 32'sd0);
    drain();
    load_sphere(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 33'h0);
    send_point(1'b1, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
    send_point(1'b1, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
    drain();
  endtask

  // Random bursts of points; before each burst one register or the whole sphere is rewritten.
  // Burst sizes stay small so that restart words are frequent.
  task automatic test_random(int count);
    int sent;
    int burst;
    logic [31:0] base [3];
    logic [31:0] spread;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 3))
        0: load_sphere($urandom, $urandom, $urandom, {1'($urandom_range(0, 1)), $urandom});
        1: load_sphere($urandom_range(0, 255) << 16, 32'(-$urandom_range(0, 999) << 12),
                       $urandom, 33'($urandom_range(0, 5) << 16));
        default: write_reg(2'($urandom_range(0, 3)), {1'($urandom_range(0, 1)), $urandom});
      endcase
      for (int k = 0; k < 3; k++) base[k] = $urandom;
      spread = 32'hFFFFFFFF >> $urandom_range(0, 28);
      burst = $urandom_range(3, 30);
      for (int n = 0; n < burst; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_point(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
        end else begin
          send_point(n == 0 || $urandom_range(0, 29) == 0,
                     base[0] + ($urandom & spread) - (spread >> 1),
                     base[1] + ($urandom & spread) - (spread >> 1),
                     base[2] + ($urandom & spread) - (spread >> 1));
        end
        sent++;
      end
      drain();
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_backpressure();
    fork
      begin
        rx_hold = 1'b1;
        repeat (3000) @(posedge clk);
        rx_hold = 1'b0;
      end
      for (int n = 0; n < 12; n++) begin
        send_point(n == 0, $urandom, $urandom, $urandom);
      end
    join
    drain();
  endtask

  initial begin
    error_count = 0;
    rx_hold = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_CX;
    cfg_wdata = '0;
    for (int k = 0; k < 3; k++) begin
      init_c[k] = '0;
      sph_c[k] = '0;
    end
    init_rad = '0;
    sph_rad = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(680);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Worst case is about 700 words, stretched by stalls.
  initial begin
    #8ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
